>>> rtl/mpm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and command/status structs for the Mandelbrot point membership block.
// Used by mpm_ctrl, mpm_datapath and mandelbrot_point_membership. No dependencies.
package mpm_pkg;

    localparam int IN_W       = 31;
    localparam int COORD_W    = 32;
    localparam int FRAC_BITS  = 28;
    localparam int HIST_DEPTH = 1;
    localparam int ITER_W     = 16;

    localparam int PROD_W = 2 * COORD_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int NX_W   = PROD_W - FRAC_BITS + 2;

    localparam int S_TDATA_W = ((2 * IN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

    localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(256);

    localparam logic signed [NX_W-1:0]  COORD_LIM = NX_W'(2) <<< FRAC_BITS;
    localparam logic signed [SUM_W-1:0] MAG_LIM   = SUM_W'(4) <<< (2 * FRAC_BITS);

    typedef enum logic [1:0] {
        OUT_ESCAPED = 2'd0,
        OUT_CYCLE   = 2'd1,
        OUT_LIMIT   = 2'd2
    } outcome_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic add;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic mag_over;
        logic at_limit;
        logic hit;
        logic out_of_bounds;
    } status_t;

endpackage

>>> rtl/mpm_datapath.sv
`timescale 1ns / 1ps
// Datapath: iteration limit register, history, squaring multipliers, next-z adders and compares.
// Depends on mpm_pkg; driven by commands from mpm_ctrl.
module mpm_datapath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr,
    input  logic [mpm_pkg::ITER_W-1:0]            cfg_data,
    input  logic signed [mpm_pkg::IN_W-1:0]       c_real,
    input  logic signed [mpm_pkg::IN_W-1:0]       c_imag,
    input  mpm_pkg::cmd_t                         cmd,
    output mpm_pkg::status_t                      status
);

    logic [mpm_pkg::ITER_W-1:0] max_iter_reg;
    logic [mpm_pkg::ITER_W-1:0] count_reg;

    logic signed [mpm_pkg::IN_W-1:0]    cr_reg;
    logic signed [mpm_pkg::IN_W-1:0]    ci_reg;
    logic signed [mpm_pkg::COORD_W-1:0] hist_r_reg [mpm_pkg::HIST_DEPTH];
    logic signed [mpm_pkg::COORD_W-1:0] hist_i_reg [mpm_pkg::HIST_DEPTH];
    logic signed [mpm_pkg::PROD_W-1:0]  xx_reg;
    logic signed [mpm_pkg::PROD_W-1:0]  yy_reg;
    logic signed [mpm_pkg::PROD_W-1:0]  xy_reg;
    logic signed [mpm_pkg::NX_W-1:0]    nx_reg;
    logic signed [mpm_pkg::NX_W-1:0]    ny_reg;

    logic signed [mpm_pkg::PROD_W-1:0] xx_next;
    logic signed [mpm_pkg::PROD_W-1:0] yy_next;
    logic signed [mpm_pkg::PROD_W-1:0] xy_next;
    logic signed [mpm_pkg::SUM_W-1:0]  diff_w;
    logic signed [mpm_pkg::SUM_W-1:0]  diff_sh;
    logic signed [mpm_pkg::PROD_W-1:0] xy_sh;
    logic signed [mpm_pkg::NX_W-1:0]   nx_next;
    logic signed [mpm_pkg::NX_W-1:0]   ny_next;
    logic signed [mpm_pkg::SUM_W-1:0]  mag_w;
    logic                              hit_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= mpm_pkg::MAX_ITER_RST;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                max_iter_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                count_reg <= '0;
            end
            else if (cmd.add)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    assign xx_next = hist_r_reg[0] * hist_r_reg[0];
    assign yy_next = hist_i_reg[0] * hist_i_reg[0];
    assign xy_next = hist_r_reg[0] * hist_i_reg[0];

    // The doubling of x*y folds into a shift that is one place shorter.
    assign diff_w  = mpm_pkg::SUM_W'(xx_reg) - mpm_pkg::SUM_W'(yy_reg);
    assign diff_sh = diff_w >>> mpm_pkg::FRAC_BITS;
    assign xy_sh   = xy_reg >>> (mpm_pkg::FRAC_BITS - 1);
    assign nx_next = mpm_pkg::NX_W'(diff_sh) + mpm_pkg::NX_W'(cr_reg);
    assign ny_next = mpm_pkg::NX_W'(xy_sh) + mpm_pkg::NX_W'(ci_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cr_reg <= c_real;
            ci_reg <= c_imag;
            for (int k = 0; k < mpm_pkg::HIST_DEPTH; k++)
            begin
                hist_r_reg[k] <= mpm_pkg::COORD_W'(c_real);
                hist_i_reg[k] <= mpm_pkg::COORD_W'(c_imag);
            end
        end
        else if (cmd.commit)
        begin
            for (int k = mpm_pkg::HIST_DEPTH - 1; k > 0; k--)
            begin
                hist_r_reg[k] <= hist_r_reg[k-1];
                hist_i_reg[k] <= hist_i_reg[k-1];
            end
            hist_r_reg[0] <= mpm_pkg::COORD_W'(nx_reg);
            hist_i_reg[0] <= mpm_pkg::COORD_W'(ny_reg);
        end
        if (cmd.mul)
        begin
            xx_reg <= xx_next;
            yy_reg <= yy_next;
            xy_reg <= xy_next;
        end
        if (cmd.add)
        begin
            nx_reg <= nx_next;
            ny_reg <= ny_next;
        end
    end

    always_comb
    begin
        hit_w = 1'b0;
        for (int k = 0; k < mpm_pkg::HIST_DEPTH; k++)
        begin
            if (nx_reg == mpm_pkg::NX_W'(hist_r_reg[k]) && ny_reg == mpm_pkg::NX_W'(hist_i_reg[k]))
            begin
                hit_w = 1'b1;
            end
        end
    end

    assign mag_w = mpm_pkg::SUM_W'(xx_reg) + mpm_pkg::SUM_W'(yy_reg);

    assign status.mag_over      = mag_w > mpm_pkg::MAG_LIM;
    assign status.at_limit      = count_reg == max_iter_reg;
    assign status.hit           = hit_w;
    assign status.out_of_bounds = nx_reg > mpm_pkg::COORD_LIM || nx_reg < -mpm_pkg::COORD_LIM
                                  || ny_reg > mpm_pkg::COORD_LIM || ny_reg < -mpm_pkg::COORD_LIM;

endmodule

>>> rtl/mpm_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences multiply, add and check steps per iteration and holds the result register.
// Depends on mpm_pkg; commands mpm_datapath and reads its status.
module mpm_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic               in_set,
    output mpm_pkg::outcome_t  outcome,
    input  mpm_pkg::status_t   status,
    output mpm_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_CHK,
        ST_FIN
    } state_t;

    state_t            state_reg;
    logic              chk_mag_reg;
    mpm_pkg::outcome_t pend_reg;
    logic              m_valid_reg;
    logic              in_set_reg;
    mpm_pkg::outcome_t outcome_reg;
    logic              slot_free;

    assign s_tready  = state_reg == ST_IDLE;
    assign m_tvalid  = m_valid_reg;
    assign in_set    = in_set_reg;
    assign outcome   = outcome_reg;
    assign slot_free = !m_valid_reg || m_tready;

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: cmd.load = s_tvalid;
            ST_MUL:  cmd.mul  = 1'b1;
            ST_ADD:  cmd.add  = !(chk_mag_reg && status.mag_over) && !status.at_limit;
            ST_CHK:  cmd.commit = !status.hit && !status.out_of_bounds;
            ST_FIN:  cmd = '0;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            chk_mag_reg <= 1'b0;
            pend_reg    <= mpm_pkg::OUT_LIMIT;
            m_valid_reg <= 1'b0;
            in_set_reg  <= 1'b0;
            outcome_reg <= mpm_pkg::OUT_LIMIT;
        end
        else
        begin
            if (state_reg == ST_FIN && slot_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        chk_mag_reg <= 1'b0;
                        state_reg   <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    // The magnitude test belongs to the z stored by the previous iteration.
                    priority if (chk_mag_reg && status.mag_over)
                    begin
                        pend_reg  <= mpm_pkg::OUT_ESCAPED;
                        state_reg <= ST_FIN;
                    end
                    else if (status.at_limit)
                    begin
                        pend_reg  <= mpm_pkg::OUT_LIMIT;
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK:
                begin
                    priority if (status.hit)
                    begin
                        pend_reg  <= mpm_pkg::OUT_CYCLE;
                        state_reg <= ST_FIN;
                    end
                    else if (status.out_of_bounds)
                    begin
                        pend_reg  <= mpm_pkg::OUT_ESCAPED;
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        chk_mag_reg <= 1'b1;
                        state_reg   <= ST_MUL;
                    end
                end
                ST_FIN:
                begin
                    if (slot_free)
                    begin
                        in_set_reg  <= pend_reg != mpm_pkg::OUT_ESCAPED;
                        outcome_reg <= pend_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/mandelbrot_point_membership.sv
`timescale 1ns / 1ps
// Top level of the Mandelbrot point membership block: stream ports, configuration port, packing.
// Depends on mpm_pkg, mpm_ctrl and mpm_datapath.
//
// Each point c is iterated as z = z*z + c in fixed point, starting from z = c. An iteration
// has a multiply step that forms x*x, y*y and x*y, an add step that forms the next z and
// tests the magnitude of the present one and the iteration count against max_iter, and a check
// step that compares the next z with the history and with the coordinate bounds. At most
// max_iter iterations are run (reset value 256). One point is worked on at a time; a new input
// transfer is taken while the previous result still waits in the output register. max_iter is
// written through the cfg channel, which is always ready; the user must write it only while
// idle, as the block itself does not enforce this.
module mandelbrot_point_membership
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mpm_pkg::ITER_W-1:0]        cfg_data,   // max_iter
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mpm_pkg::S_TDATA_W-1:0]     s_tdata,    // c_real, c_imag, zero fill
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mpm_pkg::M_TDATA_W-1:0]     m_tdata     // in_set, outcome, zero fill
);

    mpm_pkg::cmd_t     cmd;
    mpm_pkg::status_t  status;
    mpm_pkg::outcome_t outcome;
    logic              in_set;

    logic signed [mpm_pkg::IN_W-1:0] c_real;
    logic signed [mpm_pkg::IN_W-1:0] c_imag;

    assign cfg_ready = 1'b1;
    assign c_real    = s_tdata[mpm_pkg::IN_W-1:0];
    assign c_imag    = s_tdata[2*mpm_pkg::IN_W-1:mpm_pkg::IN_W];
    assign m_tdata   = mpm_pkg::M_TDATA_W'({outcome, in_set});

    mpm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .in_set   (in_set),
        .outcome  (outcome),
        .status   (status),
        .cmd      (cmd)
    );

    mpm_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .c_real   (c_real),
        .c_imag   (c_imag),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

>>> dv/tb_mandelbrot_point_membership.sv
`timescale 1ns / 1ps
// Self-checking testbench for mandelbrot_point_membership: points go in on the stream input,
// verdicts are compared with a fixed-point escape-time predictor in a small scoreboard class.
// Depends on mpm_pkg and the RTL of the block.
module tb_mandelbrot_point_membership;
    import mpm_pkg::*;

    localparam int WATCHDOG_LIMIT = 800000;
    localparam int SPAN_2P25      = 603979776;
    localparam logic signed [IN_W-1:0] C_MIN = {1'b1, {(IN_W-1){1'b0}}};
    localparam logic signed [IN_W-1:0] C_MAX = {1'b0, {(IN_W-1){1'b1}}};

    typedef struct {
        logic     in_set;
        outcome_t outcome;
    } verdict_t;

    class verdict_board;
        int unsigned max_iter;
        int unsigned last_count;
        verdict_t    expected_q[$];
        int          errors;
        int          points;
        int          tally[3];

        function new();
            max_iter = MAX_ITER_RST;
            last_count = 0;
            errors = 0;
            points = 0;
            tally = '{0, 0, 0};
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function outcome_t judge_point(logic signed [IN_W-1:0] cr, logic signed [IN_W-1:0] ci);
            logic signed [127:0] re, im, x, y, nx, ny, lim, four;
            outcome_t verdict;
            re = cr;
            im = ci;
            x = re;
            y = im;
            lim = 128'sd1 <<< (FRAC_BITS + 1);
            four = 128'sd1 <<< (2 * FRAC_BITS + 2);
            verdict = OUT_LIMIT;
            last_count = 0;
            while (last_count < max_iter) begin
                nx = ((x * x - y * y) >>> FRAC_BITS) + re;
                ny = ((2 * x * y) >>> FRAC_BITS) + im;
                last_count++;
                if (nx == x && ny == y) begin
                    verdict = OUT_CYCLE;
                    break;
                end
                if (nx > lim || nx < -lim || ny > lim || ny < -lim ||
                    nx * nx + ny * ny > four) begin
                    verdict = OUT_ESCAPED;
                    break;
                end
                x = {{(128-COORD_W){nx[COORD_W-1]}}, nx[COORD_W-1:0]};
                y = {{(128-COORD_W){ny[COORD_W-1]}}, ny[COORD_W-1:0]};
            end
            return verdict;
        endfunction

        function void note_point(logic signed [IN_W-1:0] cr, logic signed [IN_W-1:0] ci);
            verdict_t v;
            v.outcome = judge_point(cr, ci);
            v.in_set = (v.outcome != OUT_ESCAPED);
            expected_q.push_back(v);
            points++;
        endfunction

        function void check_verdict(logic in_set, logic [1:0] outcome_bits);
            verdict_t v;
            if (expected_q.size() == 0) begin
                $error("result transfer with no point outstanding: in_set %0d outcome %0d",
                       in_set, outcome_bits);
                errors++;
                return;
            end
            v = expected_q.pop_front();
            tally[v.outcome]++;
            if (in_set !== v.in_set) begin
                $error("in_set: expected %0d, actual %0d", v.in_set, in_set);
                errors++;
            end
            if (outcome_bits !== v.outcome) begin
                $error("outcome: expected %0d, actual %0d", v.outcome, outcome_bits);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [ITER_W-1:0]     cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;

    verdict_board board = new();
    int burst_left = 0;
    int idle_cycles = 0;
    int settings_used = 1;

    mandelbrot_point_membership u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [IN_W-1:0] q28(real v);
        return IN_W'($rtoi(v * 268435456.0));
    endfunction

    task automatic send_point(input logic signed [IN_W-1:0] cr, input logic signed [IN_W-1:0] ci);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W-2*IN_W){1'b0}}, ci, cr};
        do @(posedge clk); while (!s_tready);
        board.note_point(cr, ci);
    endtask

    task automatic send_real(input real re, input real im);
        send_point(q28(re), q28(im));
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic random_point(output logic signed [IN_W-1:0] cr,
                                output logic signed [IN_W-1:0] ci);
        int pick;
        int k;
        real anchor_re[7] = '{-0.75, 0.25, -1.25, -0.16, 0.285, -0.1, -1.77};
        real anchor_im[7] = '{0.1, 0.0, 0.0, 1.04, 0.01, 0.65, 0.0};
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            cr = IN_W'($urandom);
            ci = IN_W'($urandom);
        end else if (pick <= 5) begin
            cr = IN_W'(int'($urandom_range(0, 2 * SPAN_2P25)) - SPAN_2P25);
            ci = IN_W'(int'($urandom_range(0, 2 * SPAN_2P25)) - SPAN_2P25);
        end else begin
            pick = $urandom_range(0, 6);
            k = $urandom_range(4, 26);
            cr = q28(anchor_re[pick]) + IN_W'(int'($urandom_range(0, 2 << k)) - (1 << k));
            ci = q28(anchor_im[pick]) + IN_W'(int'($urandom_range(0, 2 << k)) - (1 << k));
        end
    endtask

    task automatic send_random(input int count);
        logic signed [IN_W-1:0] cr, ci;
        repeat (count) begin
            random_point(cr, ci);
            send_point(cr, ci);
        end
    endtask

    task automatic write_limit(input int unsigned limit);
        while (board.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= ITER_W'(limit);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.max_iter = limit;
        settings_used++;
    endtask

    initial
    begin
        int unsigned sweep[6];
        m_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (sweep[0] == 0) begin
                sweep[0] = $urandom_range(20, 300);
                sweep[1] = $urandom_range(0, 3);
            end
            sweep[0]--;
            sweep[2]++;
            case (sweep[1])
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= (sweep[2] % 8 == 0);
                default: m_tready <= $urandom_range(0, 1);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_verdict(m_tdata[0], m_tdata[2:1]);
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired with %0d results outstanding.", board.pending());
                $display("tb_mandelbrot_point_membership failed");
                $finish;
            end else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int unsigned limits[6];
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset limit: fixed points, alternating orbits that run to the limit, far points.
        send_real(0.0, 0.0);
        send_point(IN_W'(1), IN_W'(0));
        send_point(IN_W'(0), IN_W'(-1));
        send_real(-2.0, 0.0);
        send_real(2.0, 0.0);
        send_real(-1.0, 0.0);
        send_real(0.0, 1.0);
        send_real(0.0, -1.0);
        send_real(0.25, 0.0);
        send_real(-0.75, 0.0);
        send_point(C_MIN, C_MIN);
        send_point(C_MAX, C_MAX);
        send_point(C_MIN, C_MAX);
        send_point(C_MAX, C_MIN);
        send_point(C_MAX, IN_W'(0));
        send_point(IN_W'(0), C_MIN);
        send_real(0.3, 0.5);
        send_real(-0.1, 0.65);
        send_real(0.28, 0.01);
        end_burst();

        write_limit(0);
        send_real(0.0, 0.0);
        send_point(C_MAX, C_MAX);
        send_real(-1.0, 0.0);
        send_random(8);
        end_burst();

        write_limit(1);
        send_real(0.0, 0.0);
        send_point(IN_W'(1), IN_W'(1));
        send_real(-1.0, 0.0);
        send_point(C_MIN, C_MIN);
        send_random(10);
        end_burst();

        write_limit(65535);
        send_real(0.0, 0.0);
        send_real(-2.0, 0.0);
        send_point(C_MAX, C_MIN);
        send_real(-1.0, 0.0);
        end_burst();

        limits = '{256, 2, 48, 700, $urandom_range(3, 400), 300};
        foreach (limits[i]) begin
            write_limit(limits[i]);
            send_random(200);
            end_burst();
        end

        while (board.pending() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Checked %0d points under %0d iteration limits from 0 to 65535.",
                 board.points, settings_used);
        $display("Verdicts seen: %0d escaped, %0d cycle found, %0d limit reached.",
                 board.tally[OUT_ESCAPED], board.tally[OUT_CYCLE], board.tally[OUT_LIMIT]);
        if (board.errors == 0 && board.pending() == 0)
            $display("tb_mandelbrot_point_membership passed");
        else
            $display("tb_mandelbrot_point_membership failed");
        $finish;
    end
endmodule
